// File: design/turtle_plotter_bitmap_defines.svh
// Assertion macros shared by the turtle plotter checker.
`ifndef TURTLE_PLOTTER_BITMAP_DEFINES_SVH
`define TURTLE_PLOTTER_BITMAP_DEFINES_SVH

// Property that holds at every edge outside reset.
`define TPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked in the cycle after its trigger, outside reset.
`define TPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Property that also covers the reset cycles.
`define TPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/tpb_pkg.sv
// Shared types and constants of the turtle plotter.
package tpb_pkg;

  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int DIST_W    = 6;
  localparam int ROW_W     = 64;
  localparam int ADDR_W    = $clog2(GRID_SIZE);

  localparam logic [COORD_W-1:0] EDGE_MAX = COORD_W'(GRID_SIZE - 1);
  localparam logic [ROW_W-1:0]   ROW_MASK =
    (GRID_SIZE >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << GRID_SIZE) - ROW_W'(1));

  typedef enum logic [2:0] {
    CMD_PEN_UP   = 3'd0,
    CMD_PEN_DOWN = 3'd1,
    CMD_TURN_R   = 3'd2,
    CMD_TURN_L   = 3'd3,
    CMD_MOVE     = 3'd4,
    CMD_DUMP     = 3'd5
  } cmd_t;

  localparam logic [1:0] HEAD_NORTH = 2'd0;
  localparam logic [1:0] HEAD_EAST  = 2'd1;
  localparam logic [1:0] HEAD_SOUTH = 2'd2;
  localparam logic [1:0] HEAD_WEST  = 2'd3;

  // Commands from controller to datapath.
  typedef struct packed {
    logic set_pen;
    logic clr_pen;
    logic turn_r;
    logic turn_l;
    logic load_count;
    logic step;
    logic rd_mark;
    logic wr_mark;
    logic load_rows;
    logic rd_row;
    logic load_out;
    logic dec_row;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic pen;
    logic count_zero;
    logic count_one;
    logic row_zero;
    logic out_free;
    logic dist_zero;
  } dp_status_t;

endpackage

// File: design/tpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/tpb_ctrl.sv
// Controller state machine of the turtle plotter.
module tpb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          command,
  input  tpb_pkg::dp_status_t status,
  output tpb_pkg::dp_cmd_t    dp_cmd
);
  import tpb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MARK_RD = 6'b000010,
    ST_MARK_WR = 6'b000100,
    ST_STEP    = 6'b001000,
    ST_DUMP_RD = 6'b010000,
    ST_DUMP_LD = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(command))
            CMD_PEN_UP: dp_cmd.clr_pen = 1'b1;
            CMD_PEN_DOWN: begin
              dp_cmd.set_pen = 1'b1;
              state_next     = ST_MARK_RD;
            end
            CMD_TURN_R: dp_cmd.turn_r = 1'b1;
            CMD_TURN_L: dp_cmd.turn_l = 1'b1;
            CMD_MOVE: begin
              if (!status.dist_zero) begin
                dp_cmd.load_count = 1'b1;
                state_next        = ST_STEP;
              end
            end
            CMD_DUMP: begin
              dp_cmd.load_rows = 1'b1;
              state_next       = ST_DUMP_RD;
            end
            default: ;
          endcase
        end
      end
      ST_MARK_RD: begin
        dp_cmd.rd_mark = 1'b1;
        state_next     = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        dp_cmd.wr_mark = 1'b1;
        state_next     = status.count_zero ? ST_IDLE : ST_STEP;
      end
      ST_STEP: begin
        dp_cmd.step = 1'b1;
        if (status.pen) begin
          state_next = ST_MARK_RD;
        end else if (status.count_one) begin
          state_next = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        if (status.out_free) begin
          dp_cmd.rd_row = 1'b1;
          state_next    = ST_DUMP_LD;
        end
      end
      ST_DUMP_LD: begin
        dp_cmd.load_out = 1'b1;
        if (status.row_zero) begin
          state_next = ST_IDLE;
        end else begin
          dp_cmd.dec_row = 1'b1;
          state_next     = ST_DUMP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/tpb_datapath.sv
// Datapath of the turtle plotter: turtle state, bitmap RAM and row output register.
module tpb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tpb_pkg::dp_cmd_t              dp_cmd,
  output tpb_pkg::dp_status_t           status,
  input  logic [tpb_pkg::DIST_W-1:0]    distance,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpb_pkg::ROW_W-1:0]     row_bits,
  output logic [tpb_pkg::COORD_W-1:0]   row_index,
  output logic                          last_row
);
  import tpb_pkg::*;

  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [1:0]         heading;
  logic               pen;
  logic [DIST_W-1:0]  count;
  logic [COORD_W-1:0] row_cnt;
  logic               row_valid [GRID_SIZE];
  logic               rd_hit;

  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  mark_addr;
  logic [ROW_W-1:0]   rdata;
  logic [ROW_W-1:0]   row_data;
  logic [ROW_W-1:0]   wdata;
  logic               rd_en;

  assign mark_addr = pos_y[ADDR_W-1:0];
  assign raddr     = dp_cmd.rd_mark ? mark_addr : row_cnt[ADDR_W-1:0];
  assign rd_en     = dp_cmd.rd_mark | dp_cmd.rd_row;
  // A row never written reads as cleared.
  assign row_data  = rd_hit ? rdata : '0;
  assign wdata     = row_data | (ROW_W'(1) << pos_x);

  tpb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (GRID_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (dp_cmd.wr_mark),
    .waddr (mark_addr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit <= row_valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GRID_SIZE; i++) begin
        row_valid[i] <= 1'b0;
      end
    end else if (dp_cmd.wr_mark) begin
      row_valid[mark_addr] <= 1'b1;
    end
  end

  // Turtle state: pen, heading, position with saturation at the edges.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      heading <= HEAD_NORTH;
      pen     <= 1'b0;
      count   <= '0;
    end else begin
      if (dp_cmd.set_pen) begin
        pen <= 1'b1;
      end else if (dp_cmd.clr_pen) begin
        pen <= 1'b0;
      end
      if (dp_cmd.turn_r) begin
        heading <= heading + 2'd1;
      end else if (dp_cmd.turn_l) begin
        heading <= heading - 2'd1;
      end
      if (dp_cmd.load_count) begin
        count <= distance;
      end else if (dp_cmd.step) begin
        count <= count - DIST_W'(1);
      end
      if (dp_cmd.step) begin
        unique case (heading)
          HEAD_NORTH: if (pos_y < EDGE_MAX) pos_y <= pos_y + COORD_W'(1);
          HEAD_EAST:  if (pos_x < EDGE_MAX) pos_x <= pos_x + COORD_W'(1);
          HEAD_SOUTH: if (pos_y != '0) pos_y <= pos_y - COORD_W'(1);
          HEAD_WEST:  if (pos_x != '0) pos_x <= pos_x - COORD_W'(1);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_rows) begin
      row_cnt <= EDGE_MAX;
    end else if (dp_cmd.dec_row) begin
      row_cnt <= row_cnt - COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_out) begin
      row_bits  <= row_data & ROW_MASK;
      row_index <= row_cnt;
      last_row  <= (row_cnt == '0);
    end
  end

  assign status.pen        = pen;
  assign status.count_zero = (count == '0);
  assign status.count_one  = (count == DIST_W'(1));
  assign status.row_zero   = (row_cnt == '0);
  assign status.out_free   = !out_valid || !out_stall;
  assign status.dist_zero  = (distance == '0);

endmodule

// File: design/turtle_plotter_bitmap.sv
// Top level of the turtle plotter: controller plus datapath.
//
// Input channel (in_valid/in_stall, command, distance): one turtle command per
// transfer. in_stall is high while a command is being worked; a new command is
// taken only once the previous one has finished its work.
// Output channel (out_valid/out_stall, row_bits, row_index, last_row): a dump
// sends one transfer per grid row, top row first, last_row set on row 0.
// Work per command: pen up, turn and ignored codes finish on acceptance; pen
// down reads, modifies and writes the row under the turtle; a move steps
// distance times with the pen up, and with the pen down marks each new cell
// the same way; a dump reads and loads one row after another, pausing while the
// receiver stalls. Every mark is a read-modify-write through the bitmap RAM's
// single read port, and a dump reads each row through that same port.
// The row output register decouples the two sides: the final row of a dump may
// wait there while the next command is already accepted.
// Reset clears the per-row valid flags, so the bitmap reads as empty at once;
// it clears the position, sets heading north and pen up, and clears out_valid.
// When the receiver stalls, hold the current row and pause the dump.
module turtle_plotter_bitmap (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    command,
  input  logic [tpb_pkg::DIST_W-1:0]    distance,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpb_pkg::ROW_W-1:0]     row_bits,
  output logic [tpb_pkg::COORD_W-1:0]   row_index,
  output logic                          last_row
);
  import tpb_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t status;

  // Sequence the commands and the RAM accesses.
  tpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .status   (status),
    .dp_cmd   (dp_cmd)
  );

  // Hold turtle state, the bitmap and the row output register.
  tpb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .status    (status),
    .distance  (distance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_bits  (row_bits),
    .row_index (row_index),
    .last_row  (last_row)
  );

endmodule

// File: design/tpb_checker.sv
// Port-level checker of the turtle plotter, bound to the top level.
`include "turtle_plotter_bitmap_defines.svh"

module tpb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [2:0]                    command,
  input logic [tpb_pkg::DIST_W-1:0]    distance,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tpb_pkg::ROW_W-1:0]     row_bits,
  input logic [tpb_pkg::COORD_W-1:0]   row_index,
  input logic                          last_row
);
  import tpb_pkg::*;

  // A stalled command stays offered and unchanged.
  `TPB_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(command) && $stable(distance), "command changed while stalled")

  // A stalled row stays offered and unchanged.
  `TPB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(row_bits) && $stable(row_index) && $stable(last_row), "row changed while stalled")

  // The last flag marks row zero and only row zero.
  `TPB_ASSERT(a_last_row, !out_valid || (last_row == (row_index == '0)), "last_row mismatch")

  // A dump in progress keeps the command channel closed until its last row.
  `TPB_ASSERT(a_dump_busy, !(out_valid && !out_stall && !last_row) || in_stall,
              "command taken mid-dump")

  // Nothing is offered right after reset.
  `TPB_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid, "output valid after reset")

endmodule

bind turtle_plotter_bitmap tpb_checker u_tpb_checker (.*);
